@@ hdl/assert_macros.svh @@
// assertion macros shared by the calendar converter rtl
// clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define EPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication with the consequent checked in the following cycle
`define EPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/epc_pkg.sv @@
// shared types, constants and tables of the epoch seconds to calendar converter
// no dependencies
package epc_pkg;

  localparam int StampW = 31;
  localparam int DaysW  = 15;

  localparam int SecsPerDay  = 24 * 60 * 60;
  localparam int SecsPerHour = 60 * 60;
  localparam int SecsPerMin  = 60;
  localparam int MinsPerHour = 60;
  localparam int DaysPerWeek = 7;

  localparam int EpochYearOfs    = 1970 - 1900;
  localparam int EpochWeekday    = 4;
  localparam int LastNonleapFeb  = 58;
  localparam int LeapYearDays    = 366;
  localparam int CommonYearDays  = 365;

  // reciprocal dividers: q = (x * recip) >> shift, exact over the operand range
  // seconds per day is 128 * 675, the 675 part goes through the reciprocal
  localparam int DayPreShift   = 7;
  localparam int DayRecip      = 25451659;
  localparam int DayRecipShift = 34;
  // divide by 15 after dropping two bits, used for both divides by 60
  localparam int MinRecip      = 34953;
  localparam int MinRecipShift = 19;
  localparam int WdRecip       = 74899;
  localparam int WdRecipShift  = 19;

  // datapath operations
  localparam logic [2:0] OpNop  = 3'd0;
  localparam logic [2:0] OpLoad = 3'd1;
  localparam logic [2:0] OpDay  = 3'd2;
  localparam logic [2:0] OpHour = 3'd3;
  localparam logic [2:0] OpMin  = 3'd4;
  localparam logic [2:0] OpYear = 3'd5;
  localparam logic [2:0] OpOut  = 3'd6;
  localparam logic [2:0] OpTod  = 3'd7;

  typedef struct packed {
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic year_more;
  } sts_t;

  // first day of each month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/epc_ctrl.sv @@
// sequencer of the calendar converter: division steps, year walk, output slot
// depends on epc_pkg
module epc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  epc_pkg::sts_t    sts_i,
  output epc_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDay  = 3'd1;
  localparam logic [2:0] StTod  = 3'd2;
  localparam logic [2:0] StMin  = 3'd3;
  localparam logic [2:0] StHour = 3'd4;
  localparam logic [2:0] StYear = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = epc_pkg::OpNop;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.op = epc_pkg::OpLoad;
          state_d  = StDay;
        end
      end
      StDay: begin
        cmd_o.op = epc_pkg::OpDay;
        state_d  = StTod;
      end
      StTod: begin
        cmd_o.op = epc_pkg::OpTod;
        state_d  = StMin;
      end
      StMin: begin
        cmd_o.op = epc_pkg::OpMin;
        state_d  = StHour;
      end
      StHour: begin
        cmd_o.op = epc_pkg::OpHour;
        state_d  = StYear;
      end
      StYear: begin
        // one year taken off per cycle until the rest fits in the current year
        if (sts_i.year_more) begin
          cmd_o.op = epc_pkg::OpYear;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (slot_free) begin
          cmd_o.op    = epc_pkg::OpOut;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/epc_datapath.sv @@
// datapath of the calendar converter: reciprocal dividers, weekday and year
// registers, month lookup and output registers; depends on epc_pkg
module epc_datapath (
  input  logic                         clk_i,
  input  epc_pkg::cmd_t                cmd_i,
  output epc_pkg::sts_t                sts_o,
  input  logic [epc_pkg::StampW-1:0]   epoch_seconds_i,
  output logic [5:0]                   second_o,
  output logic [5:0]                   minute_o,
  output logic [4:0]                   hour_o,
  output logic [2:0]                   weekday_o,
  output logic [7:0]                   year_since_1900_o,
  output logic [8:0]                   day_of_year_o,
  output logic [3:0]                   month_index_o,
  output logic [4:0]                   day_of_month_o
);

  logic [epc_pkg::StampW-1:0] stamp_q;
  logic [epc_pkg::DaysW-1:0]  days_q;
  logic [16:0]                tod_q;
  logic [10:0]                mins_q;
  logic [5:0]                 sec_q;
  logic [4:0]                 hour_q;
  logic [2:0]                 wd_q;
  logic [7:0]                 year_q;

  logic [epc_pkg::StampW-epc_pkg::DayPreShift-1:0] day_x;
  logic [48:0]                day_prod;
  logic [epc_pkg::DaysW-1:0]  day_quo;
  logic [31:0]                day_secs;
  logic [31:0]                tod_full;
  logic [15:0]                wd_x;
  logic [32:0]                wd_prod;
  logic [13:0]                wd_quo;
  logic [15:0]                wd_full;
  logic [14:0]                min_x;
  logic [30:0]                min_prod;
  logic [8:0]                 hr_x;
  logic [24:0]                hr_prod;
  logic [16:0]                mins_secs;
  logic [16:0]                sec_full;
  logic [10:0]                hour_mins;
  logic [10:0]                min_full;
  logic                       leap;
  logic [8:0]                 year_len;
  logic [8:0]                 yday;
  logic [8:0]                 d;
  logic                       feb29;
  logic [3:0]                 mon;
  logic [4:0]                 mday;

  // day count: drop the power of two of 86400, then multiply by 1/675
  assign day_x    = stamp_q[epc_pkg::StampW-1:epc_pkg::DayPreShift];
  assign day_prod = {25'd0, day_x} * 49'(epc_pkg::DayRecip);
  assign day_quo  = day_prod[epc_pkg::DayRecipShift +: epc_pkg::DaysW];
  assign day_secs = 32'(days_q) * 32'(epc_pkg::SecsPerDay);
  assign tod_full = {1'b0, stamp_q} - day_secs;

  // weekday is (days + 4) mod 7
  assign wd_x    = 16'(days_q) + 16'(epc_pkg::EpochWeekday);
  assign wd_prod = {17'd0, wd_x} * 33'(epc_pkg::WdRecip);
  assign wd_quo  = wd_prod[epc_pkg::WdRecipShift +: 14];
  assign wd_full = wd_x - 16'(wd_quo) * 16'(epc_pkg::DaysPerWeek);

  // 60 = 4 * 15: two bits dropped, then multiply by 1/15
  assign min_x    = tod_q[16:2];
  assign min_prod = {16'd0, min_x} * 31'(epc_pkg::MinRecip);
  assign hr_x     = mins_q[10:2];
  assign hr_prod  = {16'd0, hr_x} * 25'(epc_pkg::MinRecip);

  assign mins_secs = 17'(mins_q) * 17'(epc_pkg::SecsPerMin);
  assign sec_full  = tod_q - mins_secs;
  assign hour_mins = 11'(hour_q) * 11'(epc_pkg::MinsPerHour);
  assign min_full  = mins_q - hour_mins;

  // 1970..2038 holds no century year other than 2000, a leap year
  assign leap      = (year_q[1:0] == 2'b00);
  assign year_len  = leap ? 9'(epc_pkg::LeapYearDays) : 9'(epc_pkg::CommonYearDays);
  assign sts_o.year_more = (days_q >= epc_pkg::DaysW'(year_len));

  // month lookup, leap day folded onto feb 28 with one added day
  always_comb begin
    yday  = days_q[8:0];
    feb29 = leap && (yday == 9'(epc_pkg::LastNonleapFeb + 1));
    if (leap && (yday > 9'(epc_pkg::LastNonleapFeb))) begin
      d = yday - 9'd1;
    end else begin
      d = yday;
    end
    mon = '0;
    for (int m = 1; m < 12; m++) begin
      if (epc_pkg::month_start(4'(m)) <= d) begin
        mon = 4'(m);
      end
    end
    mday = 5'(d - epc_pkg::month_start(mon)) + 5'd1 + {4'd0, feb29};
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      epc_pkg::OpLoad: begin
        stamp_q <= epoch_seconds_i;
        year_q  <= 8'(epc_pkg::EpochYearOfs);
      end
      epc_pkg::OpDay: begin
        days_q <= day_quo;
      end
      epc_pkg::OpTod: begin
        tod_q <= tod_full[16:0];
        wd_q  <= wd_full[2:0];
      end
      epc_pkg::OpMin: begin
        mins_q <= min_prod[epc_pkg::MinRecipShift +: 11];
      end
      epc_pkg::OpHour: begin
        hour_q <= hr_prod[epc_pkg::MinRecipShift +: 5];
        sec_q  <= sec_full[5:0];
      end
      epc_pkg::OpYear: begin
        days_q <= days_q - epc_pkg::DaysW'(year_len);
        year_q <= year_q + 8'd1;
      end
      epc_pkg::OpOut: begin
        second_o          <= sec_q;
        minute_o          <= min_full[5:0];
        hour_o            <= hour_q;
        weekday_o         <= wd_q;
        year_since_1900_o <= year_q;
        day_of_year_o     <= yday;
        month_index_o     <= mon;
        day_of_month_o    <= mday;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/epoch_seconds_to_calendar_core.sv @@
// channel   | signals                         | payload
// request   | in_valid_i / in_ready_o         | epoch_seconds_i
// result    | out_valid_o / out_ready_i       | second_o .. day_of_month_o
//
// a request steps through load, day count, time of day and weekday, minutes,
// hour and seconds, each by reciprocal multiplication, then a year walk over
// the n years past 1970 (at most 68) plus a final check, then the month
// lookup into the output register.
// reset clears the sequencer and the result valid; no memory to clear.
// a waiting result does not block the next request; a new result waits in
// the last step until the output register is free.
// depends on epc_pkg, epc_ctrl, epc_datapath and assert_macros.svh
`include "assert_macros.svh"

module epoch_seconds_to_calendar_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [epc_pkg::StampW-1:0] epoch_seconds_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [5:0]                 second_o,
  output logic [5:0]                 minute_o,
  output logic [4:0]                 hour_o,
  output logic [2:0]                 weekday_o,
  output logic [7:0]                 year_since_1900_o,
  output logic [8:0]                 day_of_year_o,
  output logic [3:0]                 month_index_o,
  output logic [4:0]                 day_of_month_o
);

  epc_pkg::cmd_t cmd;
  epc_pkg::sts_t sts;

  epc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  epc_datapath u_datapath (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .epoch_seconds_i   (epoch_seconds_i),
    .second_o          (second_o),
    .minute_o          (minute_o),
    .hour_o            (hour_o),
    .weekday_o         (weekday_o),
    .year_since_1900_o (year_since_1900_o),
    .day_of_year_o     (day_of_year_o),
    .month_index_o     (month_index_o),
    .day_of_month_o    (day_of_month_o)
  );

  `EPC_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "accepted request did not make the core busy")
  `EPC_ASSERT(a_time_range, !out_valid_o || (second_o < 6'd60 && minute_o < 6'd60 && hour_o < 5'd24 && weekday_o < 3'd7), "time of day or weekday out of range")
  `EPC_ASSERT(a_date_range, !out_valid_o || (month_index_o < 4'd12 && day_of_month_o != 5'd0 && year_since_1900_o >= 8'd70 && year_since_1900_o <= 8'd138), "date field out of range")

endmodule

@@ test/epoch_seconds_to_calendar_checker.sv @@
// checker for epoch_seconds_to_calendar_core: watches both channels, predicts the
// utc calendar date of every accepted request and compares the results in order
// depends on epc_pkg
module epoch_seconds_to_calendar_checker
  import epc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [StampW-1:0] epoch_seconds_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [5:0]        second_i,
  input  logic [5:0]        minute_i,
  input  logic [4:0]        hour_i,
  input  logic [2:0]        weekday_i,
  input  logic [7:0]        year_since_1900_i,
  input  logic [8:0]        day_of_year_i,
  input  logic [3:0]        month_index_i,
  input  logic [4:0]        day_of_month_i,
  output int                fail_count_o,
  output int                result_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] year_ofs;
    logic [8:0] yday;
    logic [3:0] month;
    logic [4:0] mday;
  } calendar_t;

  localparam int unsigned MonthFirstDay [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  calendar_t expected_dates [$];
  int        mismatches = 0;
  int        dates_seen = 0;

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic calendar_t calendar_of_stamp(input logic [StampW-1:0] stamp);
    calendar_t   c;
    int unsigned tod;
    int unsigned days;
    int unsigned year;
    int unsigned year_len;
    int unsigned d;
    int unsigned mday;
    int          m;
    tod       = stamp % SecsPerDay;
    days      = stamp / SecsPerDay;
    c.second  = tod % SecsPerMin;
    c.minute  = (tod / SecsPerMin) % 60;
    c.hour    = tod / SecsPerHour;
    c.weekday = (EpochWeekday + days) % 7;
    // walk whole years off the day count
    year     = 1900 + EpochYearOfs;
    year_len = is_leap_year(year) ? LeapYearDays : CommonYearDays;
    while (days >= year_len) begin
      days     -= year_len;
      year     += 1;
      year_len  = is_leap_year(year) ? LeapYearDays : CommonYearDays;
    end
    c.yday     = days;
    c.year_ofs = year - 1900;
    // leap day maps onto feb 28 plus one, later days shift back by one
    d    = days;
    mday = 1;
    if (is_leap_year(year) && d > LastNonleapFeb) begin
      if (d == LastNonleapFeb + 1) mday = 2;
      d -= 1;
    end
    m = 11;
    while (m > 0 && MonthFirstDay[m] > d) m--;
    c.month = m;
    c.mday  = mday + d - MonthFirstDay[m];
    return c;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    calendar_t want;
    if (rst_ni) begin
      // retire first so a result can never pair with a request taken this cycle
      if (out_valid_i && out_ready_i) begin
        dates_seen++;
        if (expected_dates.size() == 0) begin
          $error("result with no request waiting");
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          check_field("second", want.second, second_i);
          check_field("minute", want.minute, minute_i);
          check_field("hour", want.hour, hour_i);
          check_field("weekday", want.weekday, weekday_i);
          check_field("year_since_1900", want.year_ofs, year_since_1900_i);
          check_field("day_of_year", want.yday, day_of_year_i);
          check_field("month_index", want.month, month_index_i);
          check_field("day_of_month", want.mday, day_of_month_i);
        end
      end
      if (in_valid_i && in_ready_i) expected_dates.push_back(calendar_of_stamp(epoch_seconds_i));
    end
    fail_count_o   <= mismatches;
    result_count_o <= dates_seen;
    pending_o      <= expected_dates.size();
  end

endmodule

@@ test/epoch_seconds_to_calendar_core_test.sv @@
// top of the calendar converter testbench: clock, reset, request stimulus with
// bursts and gaps, result stalls and the verdict
// depends on epc_pkg, epoch_seconds_to_calendar_core and epoch_seconds_to_calendar_checker
module epoch_seconds_to_calendar_core_test;
  import epc_pkg::*;

  localparam int NumCorners = 24;
  localparam int NumRandom  = 650;
  localparam int LastDay    = 24855;  // day holding the largest 31-bit stamp

  localparam logic [StampW-1:0] CornerStamps [NumCorners] = '{
    31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
    31'd2678399,     // end of january 1970
    31'd2678400,
    31'd63071999,    // last second of 1971
    31'd68083200,    // feb 28 of a leap year
    31'd68169600,    // leap day 1972
    31'd68256000,    // mar 1 after a leap day
    31'd94694399,    // last second of day 365 in 1972
    31'd946684799,
    31'd951782400,   // leap day of a century year divisible by 400
    31'd951868800,
    31'd978307199,
    31'd2145916800,  // jan 1 2038
    31'd715827882, 31'd1431655765, 31'd1073741824,
    31'd2147483647   // largest stamp
  };

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [StampW-1:0] epoch_seconds_i = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic [5:0]        second_o;
  logic [5:0]        minute_o;
  logic [4:0]        hour_o;
  logic [2:0]        weekday_o;
  logic [7:0]        year_since_1900_o;
  logic [8:0]        day_of_year_o;
  logic [3:0]        month_index_o;
  logic [4:0]        day_of_month_o;

  int fail_count;
  int result_count;
  int pending;
  int requests_sent = 0;
  int burst_left    = 1;
  int ready_hold    = 0;

  epoch_seconds_to_calendar_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .epoch_seconds_i   (epoch_seconds_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .second_o          (second_o),
    .minute_o          (minute_o),
    .hour_o            (hour_o),
    .weekday_o         (weekday_o),
    .year_since_1900_o (year_since_1900_o),
    .day_of_year_o     (day_of_year_o),
    .month_index_o     (month_index_o),
    .day_of_month_o    (day_of_month_o)
  );

  epoch_seconds_to_calendar_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .epoch_seconds_i   (epoch_seconds_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .second_i          (second_o),
    .minute_i          (minute_o),
    .hour_i            (hour_o),
    .weekday_i         (weekday_o),
    .year_since_1900_i (year_since_1900_o),
    .day_of_year_i     (day_of_year_o),
    .month_index_i     (month_index_o),
    .day_of_month_i    (day_of_month_o),
    .fail_count_o      (fail_count),
    .result_count_o    (result_count),
    .pending_o         (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("timeout with %0d results still outstanding", requests_sent - result_count);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: segments of steady ready, short bursts, short and long stalls
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          out_ready_i <= 1'b1;
          ready_hold  <= $urandom_range(50, 300);
        end
        1, 2: begin
          out_ready_i <= 1'b1;
          ready_hold  <= $urandom_range(1, 8);
        end
        3, 4: begin
          out_ready_i <= 1'b0;
          ready_hold  <= $urandom_range(1, 12);
        end
        default: begin
          out_ready_i <= 1'b0;
          ready_hold  <= $urandom_range(30, 120);
        end
      endcase
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // sender works in bursts; valid only drops when a gap follows
  task automatic send_request(input logic [StampW-1:0] stamp);
    int gap;
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid_i      <= 1'b0;
        epoch_seconds_i <= $urandom;  // junk while idle must be ignored
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    longint unsigned stamp;
    int unsigned     year;
    int unsigned     first_day;
    int unsigned     yday;
    int unsigned     tod;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumCorners; i++) send_request(CornerStamps[i]);

    for (int i = 0; i < NumRandom; i++) begin
      case ($urandom_range(0, 2))
        0:       tod = 0;
        1:       tod = SecsPerDay - 1;
        default: tod = $urandom_range(0, SecsPerDay - 1);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: stamp = $urandom & 32'h7fff_ffff;
        3, 4:    stamp = longint'($urandom_range(0, LastDay)) * SecsPerDay + tod;
        5, 6, 7: begin
          // land on year starts, ends and the days around february
          year      = $urandom_range(1970, 2037);
          first_day = 0;
          for (int y = 1970; y < year; y++)
            first_day += is_leap_year(y) ? LeapYearDays : CommonYearDays;
          case ($urandom_range(0, 5))
            0:       yday = 0;
            1:       yday = LastNonleapFeb;
            2:       yday = LastNonleapFeb + 1;
            3:       yday = LastNonleapFeb + 2;
            4:       yday = is_leap_year(year) ? LeapYearDays - 1 : CommonYearDays - 1;
            default: yday = $urandom_range(0, CommonYearDays - 1);
          endcase
          stamp = longint'(first_day + yday) * SecsPerDay + tod;
        end
        8:       stamp = $urandom_range(0, 200000);
        default: stamp = 32'h7fff_ffff - $urandom_range(0, 400 * SecsPerDay);
      endcase
      if (stamp > 32'h7fff_ffff) stamp = 32'h7fff_ffff;
      send_request(stamp[StampW-1:0]);
    end

    if (in_valid_i) in_valid_i <= 1'b0;
    while (result_count != requests_sent) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    $display("%0d timestamps converted and checked: %0d corner cases, %0d random",
             result_count, NumCorners, NumRandom);
    $display("covered 1970 through 2038 with leap days, month and year ends, bursts and stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending != 0) $error("%0d expected results never arrived", pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
